FILE: rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg: shared types, constants and arithmetic helpers for the PID block
// Signed fixed-point helpers: saturating add and subtract, scaled multiply
// with floor rounding, and the register index codes of the config port.
// ----------------------------------------------------------------------------
package pidc_pkg;

  // Data format: signed Q16.16 in a 32-bit word.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SHIFT_W = PROD_W - FRAC_W;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Reciprocal of three for a 32-bit unsigned dividend, used with a shift of 33.
  localparam logic [DATA_W-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP3_SHIFT = DATA_W + 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_POLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_THIRD   = 3'd6;

  // Saturate a value one bit wider than the data word.
  function automatic data_t sat_wide(logic signed [DATA_W:0] v);
    data_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? DATA_MIN : DATA_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic data_t sat_add(data_t a, data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    return sat_wide(s);
  endfunction

  function automatic data_t sat_sub(data_t a, data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    return sat_wide(s);
  endfunction

  // Full product, shifted right by the fraction width (floor), then saturated.
  function automatic data_t mulq(data_t a, data_t b);
    logic signed [PROD_W-1:0]  prod;
    logic signed [SHIFT_W-1:0] sh;
    data_t r;
    prod = a * b;
    sh = prod[PROD_W-1:FRAC_W];
    if ((&sh[SHIFT_W-1:DATA_W-1]) || !(|sh[SHIFT_W-1:DATA_W-1])) begin
      r = sh[DATA_W-1:0];
    end else begin
      r = sh[SHIFT_W-1] ? DATA_MIN : DATA_MAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/pid_controller_clamped.sv
// A beat accepted passes the input register, then the stage 1, stage 2 and output registers.
// Throughput: one beat per cycle while the result side does not stall; the integrator and
// derivative filter close their loops inside the second stage, one multiply deep.
// Reset (rst_n low, synchronous): pipeline emptied, controller state zeroed,
// configuration registers back to their default gains and limits.
// ----------------------------------------------------------------------------
// pid_controller_clamped: PID controller with anti-windup and filtered D term
// Three stages: error and gain products, integrator and derivative update with
// sum, then output clamp with optional divide by three on positive outputs.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port
  input  logic                            cfg_wr_en,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]     cfg_data,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*pidc_pkg::DATA_W-1:0]   in_tdata,   // target, measured
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pidc_pkg::DATA_W-1:0]     out_tdata,  // drive
  output logic                            out_tuser   // clamped
);

  import pidc_pkg::*;

  // Configuration registers.
  logic [30:0]        prop_gain_r;
  logic [30:0]        integ_gain_r;
  logic [30:0]        deriv_gain_r;
  logic signed [17:0] deriv_pole_r;
  data_t              out_min_r;
  data_t              out_max_r;
  logic               pos_third_r;

  // Controller state.
  data_t integ_acc_r, integ_acc_nxt;
  data_t deriv_acc_r, deriv_acc_nxt;
  data_t last_error_r;
  data_t last_meas_r;

  // Pipeline registers.
  logic  s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  data_t s0_target_r, s0_meas_r;
  data_t s1_p_r, s1_ip_r, s1_dp_r;
  data_t s2_sum_r, s2_sum_nxt;
  data_t out_drive_r, out_drive_nxt;
  logic  out_clamped_r, out_clamped_nxt;

  // Stage advance controls.
  logic adv1, adv2, adv3;
  logic in_fire;

  // Stage 1 combinational values.
  data_t err, esum, dmeas;
  data_t p_nxt, ip_nxt, dp_nxt;

  // Stage 2 combinational values.
  data_t integ_sum, imax, imin, pole_term, d_sum;

  // Stage 3 combinational values.
  logic [DATA_W-1:0]   mag;
  logic [2*DATA_W-1:0] q_prod;
  data_t               quot;
  data_t               lim1;
  logic                hit1;

  // Handshake: each stage moves when the next one is empty or moving.
  assign adv3    = s2_valid_r && (!out_valid_r || out_tready);
  assign adv2    = s1_valid_r && (!s2_valid_r || adv3);
  assign adv1    = s0_valid_r && (!s1_valid_r || adv2);
  assign in_tready = !s0_valid_r || adv1;
  assign in_fire = in_tvalid && in_tready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= 31'd85197;
      integ_gain_r <= 31'd13107;
      deriv_gain_r <= 31'd1260308;
      deriv_pole_r <= -18'sd60495;
      out_min_r    <= -32'sd65536;
      out_max_r    <= 32'sd65536;
      pos_third_r  <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:  prop_gain_r  <= cfg_data[30:0];
        CFG_INTEG_GAIN: integ_gain_r <= cfg_data[30:0];
        CFG_DERIV_GAIN: deriv_gain_r <= cfg_data[30:0];
        CFG_DERIV_POLE: deriv_pole_r <= cfg_data[17:0];
        CFG_OUT_MIN:    out_min_r    <= cfg_data;
        CFG_OUT_MAX:    out_max_r    <= cfg_data;
        CFG_POS_THIRD:  pos_third_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: error terms and the three products, which need no integrator or filter state.
  // The proportional gain is read as a signed 31-bit value.
  always_comb begin
    err    = sat_sub(s0_target_r, s0_meas_r);
    esum   = sat_add(err, last_error_r);
    dmeas  = sat_sub(s0_meas_r, last_meas_r);
    p_nxt  = mulq({prop_gain_r[30], prop_gain_r}, err);
    ip_nxt = mulq({1'b0, integ_gain_r}, esum);
    dp_nxt = mulq({1'b0, deriv_gain_r}, dmeas);
  end

  // Stage 2: integrator with headroom clamp, derivative filter, and the sum.
  always_comb begin
    integ_sum = sat_add(integ_acc_r, s1_ip_r);
    imax = (out_max_r > s1_p_r) ? sat_sub(out_max_r, s1_p_r) : '0;
    imin = (out_min_r < s1_p_r) ? sat_sub(out_min_r, s1_p_r) : '0;
    if (integ_sum > imax) begin
      integ_acc_nxt = imax;
    end else if (integ_sum < imin) begin
      integ_acc_nxt = imin;
    end else begin
      integ_acc_nxt = integ_sum;
    end
    pole_term     = mulq({{(DATA_W-18){deriv_pole_r[17]}}, deriv_pole_r}, deriv_acc_r);
    d_sum         = sat_add(s1_dp_r, pole_term);
    deriv_acc_nxt = sat_sub('0, d_sum);
    s2_sum_nxt    = sat_add(sat_add(s1_p_r, integ_acc_nxt), deriv_acc_nxt);
  end

  // Stage 3: clamp to the limits; positive results may be divided by three
  // (toward zero) and clamped again.
  always_comb begin
    mag    = s2_sum_r[DATA_W-1] ? (~s2_sum_r + 1'b1) : s2_sum_r;
    q_prod = mag * RECIP3;
    quot   = {1'b0, q_prod[2*DATA_W-1:RECIP3_SHIFT]};
    if (s2_sum_r[DATA_W-1]) begin
      quot = ~quot + 1'b1;
    end

    hit1 = 1'b1;
    if (s2_sum_r > out_max_r) begin
      lim1 = out_max_r;
    end else if (s2_sum_r < out_min_r) begin
      lim1 = out_min_r;
    end else begin
      lim1 = s2_sum_r;
      hit1 = 1'b0;
    end

    out_drive_nxt   = lim1;
    out_clamped_nxt = hit1;
    if ((lim1 > 0) && pos_third_r) begin
      out_clamped_nxt = 1'b1;
      if (quot > out_max_r) begin
        out_drive_nxt = out_max_r;
      end else if (quot < out_min_r) begin
        out_drive_nxt = out_min_r;
      end else begin
        out_drive_nxt   = quot;
        out_clamped_nxt = 1'b0;
      end
    end
  end

  // Valid bits and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      integ_acc_r  <= '0;
      deriv_acc_r  <= '0;
      last_error_r <= '0;
      last_meas_r  <= '0;
    end else begin
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (adv1) begin
        s0_valid_r <= 1'b0;
      end
      if (adv1) begin
        s1_valid_r <= 1'b1;
      end else if (adv2) begin
        s1_valid_r <= 1'b0;
      end
      if (adv2) begin
        s2_valid_r <= 1'b1;
      end else if (adv3) begin
        s2_valid_r <= 1'b0;
      end
      if (adv3) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (adv1) begin
        last_error_r <= err;
        last_meas_r  <= s0_meas_r;
      end
      if (adv2) begin
        integ_acc_r <= integ_acc_nxt;
        deriv_acc_r <= deriv_acc_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_target_r <= in_tdata[DATA_W-1:0];
      s0_meas_r   <= in_tdata[2*DATA_W-1:DATA_W];
    end
    if (adv1) begin
      s1_p_r  <= p_nxt;
      s1_ip_r <= ip_nxt;
      s1_dp_r <= dp_nxt;
    end
    if (adv2) begin
      s2_sum_r <= s2_sum_nxt;
    end
    if (adv3) begin
      out_drive_r   <= out_drive_nxt;
      out_clamped_r <= out_clamped_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_clamped_r;

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the clamped PID controller
// Drives setpoint/measurement beats under several gain and limit settings and
// random idle and stall patterns, predicts each drive value with a local
// fixed-point controller model and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pidc_pkg::*;

  localparam int PIPE_LAT = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS = 40;
  localparam int HOLD_CYCLES = 60;
  localparam int Q_ONE = 65536;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
  // Index past the end of the register map; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  // Register defaults after reset.
  localparam logic [31:0] RST_PROP = 32'd85197;
  localparam logic [31:0] RST_INTEG = 32'd13107;
  localparam logic [31:0] RST_DERIV = 32'd1260308;
  localparam int RST_POLE = -60495;
  localparam int RST_MIN = -65536;
  localparam int RST_MAX = 65536;

  typedef struct packed {
    data_t drive;
    logic  clamped;
  } drive_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [2*DATA_W-1:0]    in_tdata = '0;   // target, measured
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [DATA_W-1:0]      out_tdata;       // drive
  logic                   out_tuser;       // clamped

  pid_controller_clamped dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Mirror of the configuration registers.
  logic [30:0] kp_reg;
  logic [30:0] ki_reg;
  logic [30:0] kd_reg;
  logic [17:0] pole_reg;
  data_t       lo_reg;
  data_t       hi_reg;
  logic        third_reg;

  // Controller state as the model tracks it.
  longint integ_st;
  longint prev_err_st;
  longint dfilt_st;
  longint prev_meas_st;

  drive_beat_t pending_drive[$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        stall_request = 1'b0;
  int          hold_left = 0;
  longint      walk_tgt = 0;
  longint      walk_meas = 0;

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Fixed-point model of the controller
  // ---------------------------------------------------------------------------

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // Exact product, floor shift by the fraction width, then saturate.
  function automatic longint scale_q(longint a, longint b);
    longint prod;
    prod = a * b;
    return sat_word(prod >>> FRAC_W);
  endfunction

  // Upper limit is tested first so crossed limits resolve to the maximum.
  function automatic longint clamp_to(longint v, longint lo, longint hi, output logic hit);
    hit = 1'b1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    hit = 1'b0;
    return v;
  endfunction

  function automatic drive_beat_t predict_drive(data_t tgt, data_t meas);
    longint err, p, imax, imin, dm, total, res, lo, hi;
    logic hit;
    drive_beat_t r;
    lo = longint'(lo_reg);
    hi = longint'(hi_reg);
    err = sat_word(longint'(tgt) - longint'(meas));
    // The proportional gain is taken as a signed 31-bit value.
    p = scale_q(longint'($signed(kp_reg)), err);

    // Trapezoidal integrator, then anti-windup against the headroom left by P.
    integ_st = sat_word(integ_st + scale_q(longint'(ki_reg), sat_word(err + prev_err_st)));
    imax = (hi > p) ? sat_word(hi - p) : 0;
    imin = (lo < p) ? sat_word(lo - p) : 0;
    if (integ_st > imax) integ_st = imax;
    else if (integ_st < imin) integ_st = imin;

    // Filtered derivative on the measurement.
    dm = sat_word(longint'(meas) - prev_meas_st);
    dfilt_st = sat_word(0 - sat_word(scale_q(longint'(kd_reg), dm) +
                                     scale_q(longint'($signed(pole_reg)), dfilt_st)));

    total = sat_word(sat_word(p + integ_st) + dfilt_st);
    res = clamp_to(total, lo, hi, hit);
    if (res > 0 && third_reg) res = clamp_to(total / 3, lo, hi, hit);

    prev_err_st = err;
    prev_meas_st = longint'(meas);
    r.drive = data_t'(res);
    r.clamped = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // Send one beat, with random idle cycles ahead of it; returns at a falling edge.
  task automatic send_sample(input data_t tgt, input data_t meas);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    pending_drive.push_back(predict_drive(tgt, meas));
    @(negedge clk);
  endtask

  // Stop sending, wait for every pending result, then let the pipeline empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_PROP_GAIN:  kp_reg = value[30:0];
      CFG_INTEG_GAIN: ki_reg = value[30:0];
      CFG_DERIV_GAIN: kd_reg = value[30:0];
      CFG_DERIV_POLE: pole_reg = value[17:0];
      CFG_OUT_MIN:    lo_reg = value;
      CFG_OUT_MAX:    hi_reg = value;
      CFG_POS_THIRD:  third_reg = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd, input logic [31:0] pole,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic en);
    settle();
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_DERIV_POLE, pole);
    write_reg(CFG_OUT_MIN, lo);
    write_reg(CFG_OUT_MAX, hi);
    write_reg(CFG_POS_THIRD, {31'b0, en});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic load_defaults(input logic en);
    load_config(RST_PROP, RST_INTEG, RST_DERIV, RST_POLE, RST_MIN, RST_MAX, en);
  endtask

  // Mostly realistic gains; now and then a gain or limit from the full range,
  // which can also cross the limits.
  task automatic random_config();
    logic [31:0] kp, ki, kd, pole, lo, hi;
    kp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2147483647)
                                      : $urandom_range(0, 4 * Q_ONE);
    ki = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2147483647)
                                      : $urandom_range(0, Q_ONE);
    kd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2147483647)
                                      : $urandom_range(0, 4 * Q_ONE);
    pole = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
    lo = ($urandom_range(0, 4) == 0) ? $urandom
                                      : 32'd0 - $urandom_range(0, 16 * Q_ONE);
    hi = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 16 * Q_ONE);
    load_config(kp, ki, kd, pole, lo, hi, 1'($urandom_range(0, 1)));
  endtask

  // Mostly a measurement tracking a stepping setpoint, the rest noise.
  task automatic next_sample(output data_t tgt, output data_t meas);
    case ($urandom_range(0, 9))
      0: begin
        tgt = $urandom;
        meas = $urandom;
      end
      1: begin
        tgt = data_t'(walk_tgt);
        meas = $urandom;
      end
      2, 3: begin
        tgt = data_t'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
        meas = data_t'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
      end
      default: begin
        if ($urandom_range(0, 15) == 0)
          walk_tgt = longint'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
        walk_meas = sat_word(walk_meas + (walk_tgt - walk_meas) / 8 +
                             longint'($urandom_range(0, 8192)) - 4096);
        tgt = data_t'(walk_tgt);
        meas = data_t'(walk_meas);
      end
    endcase
  endtask

  task automatic run_samples(input int n);
    data_t tgt, meas;
    for (int i = 0; i < n; i++) begin
      next_sample(tgt, meas);
      send_sample(tgt, meas);
    end
  endtask

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : check_result
    drive_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat drive=%0d", $signed(out_tdata)));
      end else begin
        want = pending_drive.pop_front();
        if (out_tdata !== want.drive)
          report_mismatch($sformatf("drive %0d, predicted %0d",
                                    $signed(out_tdata), want.drive));
        if (out_tuser !== want.clamped)
          report_mismatch($sformatf("clamped %b, predicted %b", out_tuser, want.clamped));
      end
    end
  end

  // Result side ready: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin : receiver
    if (stall_request) begin
      stall_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[pid_controller_clamped] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Small steps under the reset gains and limits.
  task automatic test_defaults();
    send_sample(Q_ONE, 0);
    send_sample(Q_ONE, Q_ONE / 2);
    send_sample(-Q_ONE, 0);
    send_sample(0, 0);
    send_sample(4 * Q_ONE, -4 * Q_ONE);
  endtask

  // Extreme inputs, saturating error and derivative, and full-scale gains.
  task automatic test_extremes();
    load_config(Q_ONE, 32'h4000, GAIN_MAX, 0, DATA_MIN, DATA_MAX, 1'b0);
    send_sample(DATA_MAX, DATA_MIN);
    send_sample(DATA_MIN, DATA_MAX);
    send_sample(DATA_MAX, DATA_MAX);
    // The measurement drops by the full range: the derivative sum hits the
    // most negative value and its negation saturates to the largest.
    send_sample(DATA_MIN, DATA_MIN);
    send_sample(0, 0);
    send_sample(0, DATA_MIN);
    load_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, Q_ONE, DATA_MIN, DATA_MAX, 1'b1);
    send_sample(1, 0);
    send_sample(Q_ONE, -Q_ONE);
    send_sample(DATA_MIN, DATA_MAX);
  endtask

  // Lower limit above the upper one, then equal limits.
  task automatic test_crossed_limits();
    load_config(RST_PROP, RST_INTEG, RST_DERIV, RST_POLE, Q_ONE, -Q_ONE, 1'b1);
    send_sample(Q_ONE, 0);
    send_sample(-Q_ONE, 0);
    send_sample(0, 0);
    load_config(RST_PROP, RST_INTEG, RST_DERIV, RST_POLE, Q_ONE / 2, Q_ONE / 2, 1'b1);
    send_sample(2 * Q_ONE, 0);
  endtask

  // A write past the register map must change nothing.
  task automatic test_ignored_index();
    load_defaults(1'b1);
    write_reg(CFG_UNUSED, $urandom);
    cfg_wr_en <= 1'b0;
    send_sample(2 * Q_ONE, 0);
    send_sample(-Q_ONE / 4, Q_ONE / 4);
  endtask

  // Positive outputs pass without the divide by three.
  task automatic test_third_disabled();
    load_defaults(1'b0);
    send_sample(Q_ONE / 2, 0);
    send_sample(Q_ONE / 8, 0);
    send_sample(3 * Q_ONE, 0);
  endtask

  // Random traffic over several settings and idle patterns, extremes included.
  task automatic test_random_phases();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 3)
        load_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, Q_ONE, DATA_MIN, DATA_MAX, 1'b1);
      else if (phase == 6)
        load_config(0, 0, 0, -Q_ONE, DATA_MIN, DATA_MIN, 1'b0);
      else
        random_config();
      case (phase / 2)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      run_samples(125);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    load_defaults(1'b1);
    idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    stall_request = 1'b1;
    @(negedge clk);
    run_samples(40);
    settle();
    stall_pct = 74;
    run_samples(20);
  endtask

  initial begin
    kp_reg = RST_PROP[30:0];
    ki_reg = RST_INTEG[30:0];
    kd_reg = RST_DERIV[30:0];
    pole_reg = RST_POLE[17:0];
    lo_reg = data_t'(RST_MIN);
    hi_reg = data_t'(RST_MAX);
    third_reg = 1'b1;
    integ_st = 0;
    prev_err_st = 0;
    dfilt_st = 0;
    prev_meas_st = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_defaults();
    test_extremes();
    test_crossed_limits();
    test_ignored_index();
    test_third_disabled();
    test_random_phases();
    test_backpressure();
    settle();

    if (err_count == 0) begin
      $display("[pid_controller_clamped] OK");
    end else begin
      $display("[pid_controller_clamped] ERROR");
    end
    $finish;
  end

endmodule
